// ===== design/drmt_pkg.sv =====
// ----------------------------------------------------------------------------
// drmt_pkg
// Shared types and constants for the disk rotation mark tracker.
// ----------------------------------------------------------------------------
package drmt_pkg;

  localparam int unsigned TRACK_BYTES_DEF = 6656;
  localparam int unsigned MARK_SLOTS_DEF  = 20;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned WAIT_W  = 19;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned FRAC_W  = 5;
  localparam int unsigned DIST_W  = 14;
  localparam int unsigned MOVE_W  = TICK_W + 1 - FRAC_W;
  localparam int unsigned VAL_W   = MOVE_W + 1;

  localparam logic [BYTE_W-1:0] ID_MARK           = 8'hfe;
  localparam logic [BYTE_W-1:0] DATA_MARK         = 8'hfb;
  localparam logic [BYTE_W-1:0] DELETED_DATA_MARK = 8'hf8;

  typedef enum logic [OP_W-1:0] {
    OP_START_SCAN = 3'd0,
    OP_SCAN_BYTE  = 3'd1,
    OP_SET_TIME   = 3'd2,
    OP_NEXT_ID    = 3'd3,
    OP_NEXT_DATA  = 3'd4,
    OP_NEXT_INDEX = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MUL,
    ST_MOD,
    ST_SEARCH,
    ST_DONE
  } state_e;

endpackage

// ===== design/disk_rotation_mark_tracker.sv =====
// ----------------------------------------------------------------------------
// disk_rotation_mark_tracker
// Tracks mark positions on one spinning track and answers time queries.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  command   op_i, track_byte_i, tick_count_i        start, busy
//  result    wait_ticks_o, head_position_o           result_valid_o
//
//  scan, time reference and unused commands finish in the idle state and leave
//  busy low; a query keeps busy high from its accept edge through the add,
//  reciprocal multiply, remainder, search and result states
//  the search walks no marks for an index query or an empty list, else it walks
//  the marks, up to MARK_SLOTS, until one at or past the head or the last one
//  the result strobe lasts one cycle and cannot be stalled
//  reset clears counts, head, fraction and tick reference; mark lists are not
//  cleared
module disk_rotation_mark_tracker
  import drmt_pkg::*;
#(
  parameter int unsigned TRACK_BYTES = TRACK_BYTES_DEF,
  parameter int unsigned MARK_SLOTS  = MARK_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   op_i,
  input  logic [BYTE_W-1:0] track_byte_i,
  input  logic [TICK_W-1:0] tick_count_i,
  output logic              result_valid_o,
  output logic [WAIT_W-1:0] wait_ticks_o,
  output logic [POS_W-1:0]  head_position_o
);

  localparam int unsigned IDX_W    = (MARK_SLOTS > 1) ? $clog2(MARK_SLOTS) : 1;
  localparam int unsigned SH_L     = $clog2(TRACK_BYTES);
  localparam int unsigned RCP_W    = VAL_W + 1;
  localparam int unsigned QUO_W    = RCP_W - SH_L;
  localparam int unsigned PROD_W   = VAL_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << (VAL_W + SH_L)) + 64'(TRACK_BYTES) - 64'd1) / 64'(TRACK_BYTES));
  localparam logic [VAL_W-1:0]  TB_VAL  = VAL_W'(TRACK_BYTES);
  localparam logic [DIST_W-1:0] TB_DIST = DIST_W'(TRACK_BYTES);
  localparam logic [CNT_W-1:0]  SLOTS_C = CNT_W'(MARK_SLOTS);
  localparam logic [POS_W-1:0]  TB_POS  = POS_W'(TRACK_BYTES);

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [CNT_W-1:0]    id_cnt_q, id_cnt_d, data_cnt_q, data_cnt_d;
  logic [POS_W-1:0]    scan_q, scan_d;
  logic [POS_W-1:0]    head_q, head_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [TICK_W-1:0]   prev_q, prev_d;
  logic [VAL_W-1:0]    rem_q, rem_d;
  logic [QUO_W-1:0]    quo_q, quo_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [POS_W-1:0]    first_q, first_d;
  logic [WAIT_W-1:0]   wait_q, wait_d;

  logic [POS_W-1:0]    id_list_q   [MARK_SLOTS];
  logic [POS_W-1:0]    data_list_q [MARK_SLOTS];

  logic                accept;
  op_e                 op_in;
  logic [TICK_W:0]     elapsed;
  logic                id_wr, data_wr;
  logic [POS_W-1:0]    entry;
  logic [CNT_W-1:0]    sel_cnt;
  logic [DIST_W-1:0]   base, gap;
  logic [PROD_W-1:0]   prod;
  logic [VAL_W-1:0]    mod_val;

  assign accept = start && !busy;
  assign op_in  = op_e'(op_i);
  assign elapsed = {1'b0, tick_count_i - prev_q} + {{(TICK_W + 1 - FRAC_W){1'b0}}, frac_q};

  assign id_wr = accept && (op_in == OP_SCAN_BYTE) && (scan_q < TB_POS)
                 && (track_byte_i == ID_MARK) && (id_cnt_q < SLOTS_C);
  assign data_wr = accept && (op_in == OP_SCAN_BYTE) && (scan_q < TB_POS)
                   && (track_byte_i == DATA_MARK || track_byte_i == DELETED_DATA_MARK)
                   && (data_cnt_q < SLOTS_C);

  assign entry   = (op_q == OP_NEXT_ID) ? id_list_q[idx_q] : data_list_q[idx_q];
  assign sel_cnt = (op_q == OP_NEXT_ID) ? id_cnt_q : data_cnt_q;
  assign gap     = base - {1'b0, head_q};

  // head modulo track length by reciprocal multiplication
  assign prod    = {{RCP_W{1'b0}}, rem_q} * {{VAL_W{1'b0}}, RECIP};
  assign mod_val = rem_q - {{(VAL_W - QUO_W){1'b0}}, quo_q} * TB_VAL;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    id_cnt_d   = id_cnt_q;
    data_cnt_d = data_cnt_q;
    scan_d     = scan_q;
    head_d     = head_q;
    frac_d     = frac_q;
    prev_d     = prev_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    idx_d      = idx_q;
    first_d    = first_q;
    wait_d     = wait_q;
    base       = TB_DIST;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_START_SCAN: begin
              id_cnt_d   = '0;
              data_cnt_d = '0;
              scan_d     = '0;
            end
            OP_SCAN_BYTE: begin
              if (scan_q < TB_POS) begin
                scan_d = scan_q + POS_W'(1);
                if (id_wr) id_cnt_d = id_cnt_q + CNT_W'(1);
                if (data_wr) data_cnt_d = data_cnt_q + CNT_W'(1);
              end
            end
            OP_SET_TIME: begin
              prev_d = tick_count_i;
            end
            OP_NEXT_ID, OP_NEXT_DATA, OP_NEXT_INDEX: begin
              op_d    = op_in;
              prev_d  = tick_count_i;
              frac_d  = elapsed[FRAC_W-1:0];
              rem_d   = {1'b0, elapsed[TICK_W:FRAC_W]};
              state_d = ST_ADD;
            end
            default: ;
          endcase
        end
      end
      ST_ADD: begin
        rem_d   = rem_q + {{(VAL_W - POS_W){1'b0}}, head_q};
        state_d = ST_MUL;
      end
      ST_MUL: begin
        quo_d   = prod[PROD_W-1:VAL_W+SH_L];
        state_d = ST_MOD;
      end
      ST_MOD: begin
        head_d  = mod_val[POS_W-1:0];
        idx_d   = '0;
        state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (op_q == OP_NEXT_INDEX) begin
          base    = TB_DIST;
          wait_d  = {gap, {FRAC_W{1'b0}}};
          state_d = ST_DONE;
        end else if (sel_cnt == '0) begin
          base    = TB_DIST + TB_DIST;
          wait_d  = {gap, {FRAC_W{1'b0}}};
          state_d = ST_DONE;
        end else begin
          if (idx_q == '0) first_d = entry;
          if (entry >= head_q) begin
            base    = {1'b0, entry};
            wait_d  = {gap, {FRAC_W{1'b0}}};
            state_d = ST_DONE;
          end else if (CNT_W'(idx_q) + CNT_W'(1) == sel_cnt) begin
            base    = TB_DIST + {1'b0, first_d};
            wait_d  = {gap, {FRAC_W{1'b0}}};
            state_d = ST_DONE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      id_cnt_q   <= '0;
      data_cnt_q <= '0;
      scan_q     <= '0;
      head_q     <= '0;
      frac_q     <= '0;
      prev_q     <= '0;
    end else begin
      state_q    <= state_d;
      id_cnt_q   <= id_cnt_d;
      data_cnt_q <= data_cnt_d;
      scan_q     <= scan_d;
      head_q     <= head_d;
      frac_q     <= frac_d;
      prev_q     <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    idx_q   <= idx_d;
    first_q <= first_d;
    wait_q  <= wait_d;
  end

  // mark lists
  always_ff @(posedge clk_i) begin
    if (id_wr) id_list_q[id_cnt_q[IDX_W-1:0]] <= scan_q;
    if (data_wr) data_list_q[data_cnt_q[IDX_W-1:0]] <= scan_q;
  end

  assign busy            = (state_q != ST_IDLE);
  assign result_valid_o  = (state_q == ST_DONE);
  assign wait_ticks_o    = wait_q;
  assign head_position_o = head_q;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the disk rotation mark tracker: drives scan passes,
// time references and mark/index queries through the start/busy command port,
// predicts every query answer with its own track model and checks each
// strobed result against the oldest pending answer.
// ----------------------------------------------------------------------------
module testbench
  import drmt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TRACK = TRACK_BYTES_DEF;
  localparam int unsigned SLOTS = MARK_SLOTS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

  typedef struct packed {
    logic [WAIT_W-1:0] wait_ticks;
    logic [POS_W-1:0]  head;
  } query_answer_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   op_i;
  logic [BYTE_W-1:0] track_byte_i;
  logic [TICK_W-1:0] tick_count_i;
  logic              result_valid_o;
  logic [WAIT_W-1:0] wait_ticks_o;
  logic [POS_W-1:0]  head_position_o;

  // track model
  logic [POS_W-1:0]  mdl_id_pos[SLOTS];
  logic [POS_W-1:0]  mdl_data_pos[SLOTS];
  int unsigned       mdl_id_cnt;
  int unsigned       mdl_data_cnt;
  int unsigned       mdl_scan_pos;
  int unsigned       mdl_head;
  int unsigned       mdl_frac;
  logic [TICK_W-1:0] mdl_ref_ticks;

  query_answer_t expected_answers[$];
  query_answer_t oldest_answer;
  int unsigned   mismatch_cnt;
  int unsigned   items_sent;
  bit            idle_enable;

  disk_rotation_mark_tracker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .track_byte_i    (track_byte_i),
    .tick_count_i    (tick_count_i),
    .result_valid_o  (result_valid_o),
    .wait_ticks_o    (wait_ticks_o),
    .head_position_o (head_position_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned bytes_to_next_mark(input int unsigned head, input bit id_list);
    int unsigned cnt;
    int unsigned pos;
    cnt = id_list ? mdl_id_cnt : mdl_data_cnt;
    if (cnt == 0) return (TRACK - head) + TRACK;
    for (int i = 0; i < cnt; i++) begin
      pos = id_list ? mdl_id_pos[i] : mdl_data_pos[i];
      if (pos >= head) return pos - head;
    end
    pos = id_list ? mdl_id_pos[0] : mdl_data_pos[0];
    return (TRACK - head) + pos;
  endfunction

  task automatic advance_tracker_model(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] tbyte,
                                       input logic [TICK_W-1:0] ticks);
    logic [TICK_W-1:0] diff;
    longint unsigned   elapsed;
    int unsigned       gap;
    query_answer_t     ans;
    case (op)
      OP_START_SCAN: begin
        mdl_id_cnt = 0;
        mdl_data_cnt = 0;
        mdl_scan_pos = 0;
      end
      OP_SCAN_BYTE: begin
        if (mdl_scan_pos < TRACK) begin
          if (tbyte == ID_MARK) begin
            if (mdl_id_cnt < SLOTS) begin
              mdl_id_pos[mdl_id_cnt] = POS_W'(mdl_scan_pos);
              mdl_id_cnt++;
            end
          end else if (tbyte == DATA_MARK || tbyte == DELETED_DATA_MARK) begin
            if (mdl_data_cnt < SLOTS) begin
              mdl_data_pos[mdl_data_cnt] = POS_W'(mdl_scan_pos);
              mdl_data_cnt++;
            end
          end
          mdl_scan_pos++;
        end
      end
      OP_SET_TIME: mdl_ref_ticks = ticks;
      OP_NEXT_ID, OP_NEXT_DATA, OP_NEXT_INDEX: begin
        diff = ticks - mdl_ref_ticks;
        elapsed = diff;
        elapsed = elapsed + mdl_frac;
        mdl_frac = 32'(elapsed % 32);
        mdl_ref_ticks = ticks;
        mdl_head = 32'((longint'(mdl_head) + (elapsed / 32)) % TRACK);
        if (op == OP_NEXT_INDEX) gap = TRACK - mdl_head;
        else gap = bytes_to_next_mark(mdl_head, op == OP_NEXT_ID);
        ans.wait_ticks = WAIT_W'(gap * 32);
        ans.head = POS_W'(mdl_head);
        expected_answers.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // tick value that lands the head on target, with random leftover ticks
  function automatic logic [TICK_W-1:0] ticks_to_reach(input int unsigned target);
    int unsigned hops;
    hops = (target + TRACK - mdl_head) % TRACK;
    if (hops == 0 && mdl_frac != 0) hops = TRACK;
    hops += TRACK * $urandom_range(0, 2);
    return mdl_ref_ticks + hops * 32 - mdl_frac + $urandom_range(0, 31);
  endfunction

  task automatic send_command(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] tbyte,
                              input logic [TICK_W-1:0] ticks);
    @(negedge clk_i);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    start = 1'b1;
    op_i = op;
    track_byte_i = tbyte;
    tick_count_i = ticks;
    do @(posedge clk_i); while (busy);
    advance_tracker_model(op, tbyte, ticks);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_answers.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: wait %0d head %0d", wait_ticks_o, head_position_o);
      end else begin
        oldest_answer = expected_answers.pop_front();
        if (wait_ticks_o !== oldest_answer.wait_ticks
            || head_position_o !== oldest_answer.head) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: wait exp %0d got %0d, head exp %0d got %0d",
                     oldest_answer.wait_ticks, wait_ticks_o, oldest_answer.head,
                     head_position_o);
        end
      end
    end
  end

  function automatic logic [BYTE_W-1:0] pick_track_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return ID_MARK;
      3, 4:    return DATA_MARK;
      5:       return DELETED_DATA_MARK;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_head_target();
    int unsigned k;
    case ($urandom_range(0, 5))
      0: begin
        if (mdl_id_cnt == 0) return 0;
        k = mdl_id_pos[$urandom_range(0, mdl_id_cnt - 1)];
        return (k + TRACK + $urandom_range(0, 2) - 1) % TRACK;
      end
      1: begin
        if (mdl_data_cnt == 0) return TRACK - 1;
        k = mdl_data_pos[$urandom_range(0, mdl_data_cnt - 1)];
        return (k + TRACK + $urandom_range(0, 2) - 1) % TRACK;
      end
      2: return $urandom_range(0, 1) ? 0 : TRACK - 1;
      default: return $urandom_range(0, TRACK - 1);
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] pick_query_ticks();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ticks_to_reach(pick_head_target());
      4, 5, 6:    return mdl_ref_ticks + $urandom_range(0, 4096);
      7, 8:       return $urandom;
      default:    return mdl_ref_ticks + $urandom_range(0, 32'h00ff_ffff);
    endcase
  endfunction

  task automatic test_reset_queries();
    send_command(OP_NEXT_ID, 8'h00, 32'h0000_0000);
    send_command(OP_NEXT_DATA, 8'hff, 32'h0000_0000);
    send_command(OP_NEXT_INDEX, 8'h00, 32'h0000_001f);
    send_command(OP_NEXT_INDEX, 8'h00, ticks_to_reach(TRACK - 1));
    drain_results();
  endtask

  task automatic test_time_reference();
    send_command(OP_SET_TIME, 8'h00, 32'hffff_ffff);
    send_command(OP_NEXT_INDEX, 8'h00, 32'h0000_001f);
    send_command(OP_SET_TIME, 8'hff, 32'h8000_0000);
    send_command(OP_NEXT_ID, 8'h00, 32'h7fff_ffff);
    send_command(OP_SET_TIME, 8'h00, 32'h0000_0000);
    send_command(OP_NEXT_DATA, 8'h00, 32'hffff_ffff);
    drain_results();
  endtask

  task automatic test_mark_search();
    logic [BYTE_W-1:0] pattern[8];
    pattern = '{ID_MARK, 8'h00, DATA_MARK, DELETED_DATA_MARK, ID_MARK, 8'hff, 8'h7f, ID_MARK};
    send_command(OP_START_SCAN, 8'h00, 32'h0000_0000);
    foreach (pattern[i]) send_command(OP_SCAN_BYTE, pattern[i], 32'h0000_0000);
    send_command(OP_NEXT_ID, 8'h00, ticks_to_reach(4));
    send_command(OP_NEXT_ID, 8'h00, ticks_to_reach(5));
    send_command(OP_NEXT_ID, 8'h00, ticks_to_reach(8));
    send_command(OP_NEXT_DATA, 8'h00, ticks_to_reach(3));
    send_command(OP_NEXT_DATA, 8'h00, ticks_to_reach(TRACK - 1));
    send_command(OP_NEXT_INDEX, 8'h00, ticks_to_reach(0));
    drain_results();
  endtask

  task automatic test_full_lists();
    send_command(OP_START_SCAN, 8'h00, 32'h0000_0000);
    for (int i = 0; i < 2 * SLOTS + 10; i++)
      send_command(OP_SCAN_BYTE, (i % 2) ? ID_MARK : DATA_MARK, 32'h0000_0000);
    send_command(OP_NEXT_ID, 8'h00, ticks_to_reach(2 * SLOTS + 5));
    send_command(OP_NEXT_DATA, 8'h00, ticks_to_reach(2 * SLOTS - 2));
    drain_results();
  endtask

  task automatic test_track_end();
    logic [BYTE_W-1:0] b;
    idle_enable = 1'b0;
    send_command(OP_START_SCAN, 8'h00, 32'h0000_0000);
    for (int unsigned p = 0; p < TRACK + 8; p++) begin
      if (p == 0 || p == TRACK - 2 || p >= TRACK) b = ID_MARK;
      else if (p == TRACK - 1) b = DELETED_DATA_MARK;
      else if ($urandom_range(0, 499) == 0) b = pick_track_byte();
      else b = $urandom_range(0, 1) ? 8'h00 : 8'h4e;
      send_command(OP_SCAN_BYTE, b, 32'h0000_0000);
    end
    idle_enable = 1'b1;
    // scan without a new start stays parked at the track end
    send_command(OP_SCAN_BYTE, DATA_MARK, 32'h0000_0000);
    send_command(OP_NEXT_ID, 8'h00, ticks_to_reach(TRACK - 1));
    send_command(OP_NEXT_ID, 8'h00, ticks_to_reach(TRACK - 2));
    send_command(OP_NEXT_DATA, 8'h00, ticks_to_reach(TRACK - 1));
    send_command(OP_NEXT_DATA, 8'h00, ticks_to_reach(0));
    send_command(OP_NEXT_ID, 8'h00, ticks_to_reach($urandom_range(1, TRACK - 3)));
    drain_results();
  endtask

  task automatic test_unused_ops();
    send_command(OP_RSVD_A, 8'hfe, 32'hffff_ffff);
    send_command(OP_RSVD_B, 8'hfb, 32'h1234_5678);
    send_command(OP_NEXT_INDEX, 8'h00, ticks_to_reach(1));
    send_command(OP_RSVD_B, 8'hf8, 32'h0000_0000);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned       start_cnt;
    int unsigned       n;
    logic [OP_W-1:0]   op;
    start_cnt = items_sent;
    while (items_sent - start_cnt < RANDOM_ITEMS) begin
      if (items_sent - start_cnt > RANDOM_ITEMS - 300) idle_enable = 1'b0;
      if ($urandom_range(0, 4) != 0)
        send_command(OP_START_SCAN, BYTE_W'($urandom), $urandom);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 40);
      repeat (n) send_command(OP_SCAN_BYTE, pick_track_byte(), $urandom);
      n = $urandom_range(1, 12);
      repeat (n) begin
        case ($urandom_range(0, 19))
          0, 1, 2:    op = OP_SET_TIME;
          3:          op = $urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B;
          4:          op = $urandom_range(0, 1) ? OP_START_SCAN : OP_SCAN_BYTE;
          5, 6, 7, 8: op = OP_NEXT_INDEX;
          default:    op = $urandom_range(0, 1) ? OP_NEXT_ID : OP_NEXT_DATA;
        endcase
        send_command(op, BYTE_W'($urandom), (op == OP_SET_TIME && $urandom_range(0, 1))
                                            ? $urandom : pick_query_ticks());
      end
      if ($urandom_range(0, 15) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    start = 1'b0;
    op_i = '0;
    track_byte_i = '0;
    tick_count_i = '0;
    rst_ni = 1'b0;
    mismatch_cnt = 0;
    items_sent = 0;
    idle_enable = 1'b1;
    mdl_id_cnt = 0;
    mdl_data_cnt = 0;
    mdl_scan_pos = 0;
    mdl_head = 0;
    mdl_frac = 0;
    mdl_ref_ticks = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_queries();
    test_time_reference();
    test_mark_search();
    test_full_lists();
    test_track_end();
    test_unused_ops();
    test_random_traffic();

    repeat (100) @(posedge clk_i);
    if (expected_answers.size() != 0) begin
      mismatch_cnt += expected_answers.size();
      $display("%0d answers never arrived", expected_answers.size());
    end
    if (mismatch_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
